// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the quaternion core.
// No dependencies; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ETQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ETQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ETQ_ASSERT(label, clk, rst, prop, msg)
`define ETQ_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== src/etq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the quaternion core.
// No dependencies.
package etq_pkg;
   localparam int ANGLE_BITS_DEF     = 16;
   localparam int COMPONENT_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int MAX_STEPS          = 30;
   localparam int FRAC               = 30;
   localparam int WORK_BITS          = 34;
   localparam int MUL_BITS           = 32;
   localparam int NUM_AXES           = 3;
   localparam longint PI_Q30         = 64'd3373259426;
   localparam longint GAIN_Q30       = 64'd652032874;

   typedef logic signed [WORK_BITS-1:0] work_type;

   function automatic work_type atan_q30(input int idx);
      work_type r;
      case (idx)
         0:  r = work_type'(843314857);
         1:  r = work_type'(497837829);
         2:  r = work_type'(263043837);
         3:  r = work_type'(133525159);
         4:  r = work_type'(67021687);
         5:  r = work_type'(33543516);
         6:  r = work_type'(16775851);
         7:  r = work_type'(8388437);
         8:  r = work_type'(4194283);
         9:  r = work_type'(2097149);
         10: r = work_type'(1048576);
         11: r = work_type'(524288);
         12: r = work_type'(262144);
         13: r = work_type'(131072);
         14: r = work_type'(65536);
         15: r = work_type'(32768);
         16: r = work_type'(16384);
         17: r = work_type'(8192);
         18: r = work_type'(4096);
         19: r = work_type'(2048);
         20: r = work_type'(1024);
         21: r = work_type'(512);
         22: r = work_type'(256);
         23: r = work_type'(128);
         24: r = work_type'(64);
         25: r = work_type'(32);
         26: r = work_type'(16);
         27: r = work_type'(8);
         28: r = work_type'(4);
         29: r = work_type'(2);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q2.30 product, round half up: floor((a*b + 2^29) / 2^30).
   function automatic work_type mulq(input work_type a, input work_type b);
      logic signed [2*MUL_BITS-1:0] p;
      p = $signed(a[MUL_BITS-1:0]) * $signed(b[MUL_BITS-1:0]);
      p = p + (2*MUL_BITS)'(64'd1 << (FRAC - 1));
      return WORK_BITS'(p >>> FRAC);
   endfunction
endpackage

// ===== src/etq_angle_prep.sv =====
// Input stage: clamp each angle to +/-pi and form the Q2.30 half angle.
// Depends on etq_pkg.
module etq_angle_prep import etq_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         valid_i,
   input  logic signed [ANGLE_BITS-1:0] angle_i [NUM_AXES],
   output logic                         valid_o,
   output work_type                     z_o [NUM_AXES]
);
   localparam int FA = ANGLE_BITS - 3;
   localparam int SH = FRAC - FA;
   localparam longint LIM = (PI_Q30 + (64'd1 << (SH - 1))) >> SH;
   localparam int UP = FRAC - 1 - FA;

   logic     valid_ff;
   work_type z_ff [NUM_AXES];
   work_type z_in [NUM_AXES];

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         work_type a;
         a = WORK_BITS'(angle_i[k]);
         if (a > work_type'(LIM)) a = work_type'(LIM);
         if (a < -work_type'(LIM)) a = -work_type'(LIM);
         z_in[k] = a <<< UP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      z_ff <= z_in;
   end

   assign valid_o = valid_ff;
   assign z_o     = z_ff;
endmodule

// ===== src/etq_cordic.sv =====
// Rotation-mode CORDIC, one register stage per iteration, three axes in lockstep.
// Depends on etq_pkg.
module etq_cordic import etq_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     valid_i,
   input  work_type z_i [NUM_AXES],
   output logic     valid_o,
   output work_type cos_o [NUM_AXES],
   output work_type sin_o [NUM_AXES]
);
   localparam int STEPS = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

   logic     valid_ff [STEPS];
   work_type x_ff [STEPS][NUM_AXES];
   work_type y_ff [STEPS][NUM_AXES];
   work_type z_ff [STEPS][NUM_AXES];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic     v_src;
      work_type x_src [NUM_AXES];
      work_type y_src [NUM_AXES];
      work_type z_src [NUM_AXES];

      if (i == 0) begin : g_first
         assign v_src = valid_i;
         for (genvar k = 0; k < NUM_AXES; k++) begin : g_ax
            assign x_src[k] = work_type'(GAIN_Q30);
            assign y_src[k] = '0;
            assign z_src[k] = z_i[k];
         end
      end else begin : g_next
         assign v_src = valid_ff[i-1];
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= v_src;
         end
         for (int k = 0; k < NUM_AXES; k++) begin
            if (!z_src[k][WORK_BITS-1]) begin
               x_ff[i][k] <= x_src[k] - (y_src[k] >>> i);
               y_ff[i][k] <= y_src[k] + (x_src[k] >>> i);
               z_ff[i][k] <= z_src[k] - atan_q30(i);
            end else begin
               x_ff[i][k] <= x_src[k] + (y_src[k] >>> i);
               y_ff[i][k] <= y_src[k] - (x_src[k] >>> i);
               z_ff[i][k] <= z_src[k] + atan_q30(i);
            end
         end
      end
   end

   assign valid_o = valid_ff[STEPS-1];
   assign cos_o   = x_ff[STEPS-1];
   assign sin_o   = y_ff[STEPS-1];
endmodule

// ===== src/etq_quat_mul.sv =====
// Triple products, sums, rounding and saturation over three register stages.
// Depends on etq_pkg.
module etq_quat_mul import etq_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             valid_i,
   input  work_type                         cos_i [NUM_AXES],
   input  work_type                         sin_i [NUM_AXES],
   output logic                             valid_o,
   output logic signed [COMPONENT_BITS-1:0] quat_o [4]
);
   localparam int SH = FRAC - (COMPONENT_BITS - 2);
   localparam longint RND = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;
   localparam longint ONE = 64'd1 << (COMPONENT_BITS - 2);
   localparam int SUM_BITS = WORK_BITS + 2;

   typedef logic signed [SUM_BITS-1:0] sum_type;

   logic     v1_ff, v2_ff, v3_ff;
   work_type cc_ff, ss_ff, sc_ff, cs_ff, c3_ff, s3_ff;
   work_type t_ff [8];
   logic signed [COMPONENT_BITS-1:0] q_ff [4];
   logic signed [COMPONENT_BITS-1:0] q_in [4];

   function automatic logic signed [COMPONENT_BITS-1:0] to_comp(input sum_type v);
      sum_type r;
      r = (v + sum_type'(RND)) >>> SH;
      if (r > sum_type'(ONE)) r = sum_type'(ONE);
      if (r < -sum_type'(ONE)) r = -sum_type'(ONE);
      return COMPONENT_BITS'(r);
   endfunction

   always_comb begin
      q_in[0] = to_comp(SUM_BITS'(t_ff[0]) + SUM_BITS'(t_ff[1]));
      q_in[1] = to_comp(SUM_BITS'(t_ff[2]) - SUM_BITS'(t_ff[3]));
      q_in[2] = to_comp(SUM_BITS'(t_ff[4]) + SUM_BITS'(t_ff[5]));
      q_in[3] = to_comp(SUM_BITS'(t_ff[6]) - SUM_BITS'(t_ff[7]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      // pair products of roll and pitch
      cc_ff <= mulq(cos_i[0], cos_i[1]);
      ss_ff <= mulq(sin_i[0], sin_i[1]);
      sc_ff <= mulq(sin_i[0], cos_i[1]);
      cs_ff <= mulq(cos_i[0], sin_i[1]);
      c3_ff <= cos_i[2];
      s3_ff <= sin_i[2];
      // fold in yaw
      t_ff[0] <= mulq(cc_ff, c3_ff);
      t_ff[1] <= mulq(ss_ff, s3_ff);
      t_ff[2] <= mulq(sc_ff, c3_ff);
      t_ff[3] <= mulq(cs_ff, s3_ff);
      t_ff[4] <= mulq(cs_ff, c3_ff);
      t_ff[5] <= mulq(sc_ff, s3_ff);
      t_ff[6] <= mulq(cc_ff, s3_ff);
      t_ff[7] <= mulq(ss_ff, c3_ff);
      q_ff    <= q_in;
   end

   assign valid_o = v3_ff;
   assign quat_o  = q_ff;
endmodule

// ===== src/euler_to_quaternion_core.sv =====
// Euler angles (ZYX) to quaternion, fully pipelined.
// Registered path from start to rsp_valid: angle prep, the CORDIC stages, then the product, sum and output registers.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset clears only the valid chain; data registers are left as they are.
// Depends on etq_pkg, etq_angle_prep, etq_cordic, etq_quat_mul, assert_macros.svh.
`include "assert_macros.svh"
module euler_to_quaternion_core import etq_pkg::*; #(
   parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [ANGLE_BITS-1:0]     req_x_axis_angle,
   input  logic signed [ANGLE_BITS-1:0]     req_y_axis_angle,
   input  logic signed [ANGLE_BITS-1:0]     req_z_axis_angle,
   output logic                             rsp_valid,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_w,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_x,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_y,
   output logic signed [COMPONENT_BITS-1:0] rsp_quat_z
);
   localparam int STEPS   = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
   localparam int LATENCY = STEPS + 4;
   localparam longint ONE = 64'd1 << (COMPONENT_BITS - 2);

   logic accept;
   logic prep_valid, cordic_valid;
   logic signed [ANGLE_BITS-1:0] angles [NUM_AXES];
   work_type half_angle [NUM_AXES];
   work_type cos_half [NUM_AXES];
   work_type sin_half [NUM_AXES];
   logic signed [COMPONENT_BITS-1:0] quat [4];

   // every stage advances each cycle, so an item is never held off
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign angles[0] = req_x_axis_angle;
   assign angles[1] = req_y_axis_angle;
   assign angles[2] = req_z_axis_angle;

   // clamp to +/-pi and halve
   etq_angle_prep #(.ANGLE_BITS(ANGLE_BITS)) u_prep (
      .clock   (clock),
      .reset   (reset),
      .valid_i (accept),
      .angle_i (angles),
      .valid_o (prep_valid),
      .z_o     (half_angle)
   );

   // sine and cosine of each half angle, one stage per iteration
   etq_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .valid_i (prep_valid),
      .z_i     (half_angle),
      .valid_o (cordic_valid),
      .cos_o   (cos_half),
      .sin_o   (sin_half)
   );

   // combine into w, x, y, z; last stage is the output register
   etq_quat_mul #(.COMPONENT_BITS(COMPONENT_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .valid_i (cordic_valid),
      .cos_i   (cos_half),
      .sin_i   (sin_half),
      .valid_o (rsp_valid),
      .quat_o  (quat)
   );

   assign rsp_quat_w = quat[0];
   assign rsp_quat_x = quat[1];
   assign rsp_quat_y = quat[2];
   assign rsp_quat_z = quat[3];

   `ETQ_ASSERT(a_latency, clock, reset, rsp_valid |-> $past(accept, LATENCY), "result without item")
   `ETQ_ASSERT(a_w_range, clock, reset, rsp_valid |-> (rsp_quat_w <= COMPONENT_BITS'(ONE) && rsp_quat_w >= -COMPONENT_BITS'(ONE)), "w out of range")
   `ETQ_ASSERT(a_x_range, clock, reset, rsp_valid |-> (rsp_quat_x <= COMPONENT_BITS'(ONE) && rsp_quat_x >= -COMPONENT_BITS'(ONE)), "x out of range")
   `ETQ_ASSERT_NEVER(a_cordic_order, clock, reset, cordic_valid && !$past(prep_valid, STEPS), "cordic valid out of step")
endmodule
